### sv/sha256sh_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
`timescale 1ns / 1ps

package sha256sh_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BlockW    = 512;
  localparam int unsigned FillW     = 6;
  localparam int unsigned RoundW    = 6;
  localparam int unsigned MsgCntW   = 61;
  localparam int unsigned LenW      = 64;
  localparam int unsigned NumWords  = 8;
  localparam int unsigned WordIdxW  = 3;

  localparam logic [FillW-1:0]    FillLast    = 6'd63;
  localparam logic [FillW-1:0]    FillLenPos  = 6'd56;
  localparam logic [RoundW-1:0]   RoundLast   = 6'd63;
  localparam logic [WordIdxW-1:0] WordIdxLast = 3'd7;
  localparam logic [ByteW-1:0]    PadByte     = 8'h80;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_COMP,
    S_ADD,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_DATA,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN
  } byte_sel_t;

  typedef struct packed {
    logic                shift_byte;
    byte_sel_t           byte_sel;
    logic [2:0]          len_idx;
    logic                init_vars;
    logic                round;
    logic [RoundW-1:0]   round_idx;
    logic                add_chain;
    logic                load_out;
    logic                shift_out;
  } cmd_t;

  function automatic logic [WordW-1:0] iv(input logic [WordIdxW-1:0] idx);
    logic [WordW-1:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] k_const(input logic [RoundW-1:0] r);
    logic [WordW-1:0] k;
    unique case (r)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x,
                                            input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [WordW-1:0] ssig0(input logic [WordW-1:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] ssig1(input logic [WordW-1:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### sv/sha256sh_ctrl.sv
// Sequencer for byte intake, padding, compression rounds and digest drain.
`timescale 1ns / 1ps

module sha256sh_ctrl
  import sha256sh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                byte_valid,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WordIdxW-1:0] word_index,
  output logic                last_word,
  output cmd_t                cmd
);

  state_t              state, state_next;
  logic [FillW-1:0]    fill, fill_next;
  logic                pad_first, pad_first_next;
  logic                ret_pad, ret_pad_next;
  logic                final_blk, final_blk_next;
  logic [RoundW-1:0]   rnd, rnd_next;
  logic [2:0]          lcnt, lcnt_next;
  logic                out_vld, out_vld_next;
  logic [WordIdxW-1:0] out_idx, out_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      pad_first <= 1'b0;
      ret_pad   <= 1'b0;
      final_blk <= 1'b0;
      rnd       <= '0;
      lcnt      <= '0;
      out_vld   <= 1'b0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      pad_first <= pad_first_next;
      ret_pad   <= ret_pad_next;
      final_blk <= final_blk_next;
      rnd       <= rnd_next;
      lcnt      <= lcnt_next;
      out_vld   <= out_vld_next;
      out_idx   <= out_idx_next;
    end
  end

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    pad_first_next = pad_first;
    ret_pad_next   = ret_pad;
    final_blk_next = final_blk;
    rnd_next       = rnd;
    lcnt_next      = lcnt;
    out_vld_next   = out_vld;
    out_idx_next   = out_idx;
    cmd            = '0;
    cmd.byte_sel   = SEL_DATA;
    cmd.len_idx    = lcnt;
    cmd.round_idx  = rnd;
    in_stall       = (state != S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (byte_valid) begin
            cmd.shift_byte = 1'b1;
            fill_next      = fill + 1'b1;
            if (fill == FillLast) begin
              // block full: compress first, pad afterwards if this was the end
              cmd.init_vars  = 1'b1;
              state_next     = S_COMP;
              ret_pad_next   = last_byte;
              final_blk_next = 1'b0;
              pad_first_next = 1'b1;
            end else if (last_byte) begin
              state_next     = S_PAD;
              pad_first_next = 1'b1;
            end
          end else if (last_byte) begin
            state_next     = S_PAD;
            pad_first_next = 1'b1;
          end
        end
      end
      S_PAD: begin
        if (!pad_first && fill == FillLenPos) begin
          state_next = S_LEN;
          lcnt_next  = '0;
        end else begin
          cmd.shift_byte = 1'b1;
          cmd.byte_sel   = pad_first ? SEL_PAD80 : SEL_ZERO;
          pad_first_next = 1'b0;
          fill_next      = fill + 1'b1;
          if (fill == FillLast) begin
            // no room for the length: extra block
            cmd.init_vars  = 1'b1;
            state_next     = S_COMP;
            ret_pad_next   = 1'b1;
            final_blk_next = 1'b0;
          end
        end
      end
      S_LEN: begin
        cmd.shift_byte = 1'b1;
        cmd.byte_sel   = SEL_LEN;
        fill_next      = fill + 1'b1;
        lcnt_next      = lcnt + 1'b1;
        if (lcnt == 3'd7) begin
          cmd.init_vars  = 1'b1;
          state_next     = S_COMP;
          ret_pad_next   = 1'b0;
          final_blk_next = 1'b1;
        end
      end
      S_COMP: begin
        cmd.round = 1'b1;
        rnd_next  = rnd + 1'b1;
        if (rnd == RoundLast) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        cmd.add_chain = 1'b1;
        if (final_blk) begin
          state_next = S_DONE;
        end else if (ret_pad) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        // wait for the previous digest to drain before handing over
        if (!out_vld) begin
          cmd.load_out = 1'b1;
          out_vld_next = 1'b1;
          out_idx_next = '0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (out_vld && !out_stall) begin
      cmd.shift_out = 1'b1;
      out_idx_next  = out_idx + 1'b1;
      if (out_idx == WordIdxLast) begin
        out_vld_next = 1'b0;
      end
    end
  end

  assign out_valid  = out_vld;
  assign word_index = out_idx;
  assign last_word  = (out_idx == WordIdxLast);

endmodule

### sv/sha256sh_dp.sv
// Block shift buffer, message schedule, round unit, chaining value and digest buffer.
`timescale 1ns / 1ps

module sha256sh_dp
  import sha256sh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  input  logic [ByteW-1:0] data_byte,
  output logic [WordW-1:0] digest_word
);

  logic [BlockW-1:0]  blk;
  logic [WordW-1:0]   wv    [NumWords];
  logic [WordW-1:0]   chain [NumWords];
  logic [WordW-1:0]   dig   [NumWords];
  logic [MsgCntW-1:0] msg_bytes;

  logic [LenW-1:0]    bit_len;
  logic [ByteW-1:0]   len_byte;
  logic [ByteW-1:0]   in_byte;
  logic [WordW-1:0]   w0, w1, w9, w14, w_new;
  logic [WordW-1:0]   t1, t2, ch, maj;

  assign bit_len  = {msg_bytes, 3'b000};
  assign len_byte = bit_len[(LenW - ByteW) - ByteW * cmd.len_idx +: ByteW];

  always_comb begin
    unique case (cmd.byte_sel)
      SEL_DATA:  in_byte = data_byte;
      SEL_PAD80: in_byte = PadByte;
      SEL_ZERO:  in_byte = '0;
      SEL_LEN:   in_byte = len_byte;
      default:   in_byte = '0;
    endcase
  end

  // word t of the schedule sits at the top of the window
  assign w0    = blk[BlockW-1 -: WordW];
  assign w1    = blk[BlockW-1-WordW -: WordW];
  assign w9    = blk[BlockW-1-9*WordW -: WordW];
  assign w14   = blk[BlockW-1-14*WordW -: WordW];
  assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;

  assign ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t1  = wv[7] + bsig1(wv[4]) + ch + k_const(cmd.round_idx) + w0;
  assign t2  = bsig0(wv[0]) + maj;

  always_ff @(posedge clk) begin
    if (cmd.shift_byte) begin
      blk <= {blk[BlockW-ByteW-1:0], in_byte};
    end else if (cmd.round) begin
      blk <= {blk[BlockW-WordW-1:0], w_new};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_vars) begin
      for (int i = 0; i < NumWords; i++) begin
        wv[i] <= chain[i];
      end
    end else if (cmd.round) begin
      wv[0] <= t1 + t2;
      wv[1] <= wv[0];
      wv[2] <= wv[1];
      wv[3] <= wv[2];
      wv[4] <= wv[3] + t1;
      wv[5] <= wv[4];
      wv[6] <= wv[5];
      wv[7] <= wv[6];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumWords; i++) begin
        chain[i] <= iv(WordIdxW'(i));
      end
      msg_bytes <= '0;
    end else begin
      if (cmd.add_chain) begin
        for (int i = 0; i < NumWords; i++) begin
          chain[i] <= chain[i] + wv[i];
        end
      end else if (cmd.load_out) begin
        for (int i = 0; i < NumWords; i++) begin
          chain[i] <= iv(WordIdxW'(i));
        end
      end
      if (cmd.load_out) begin
        msg_bytes <= '0;
      end else if (cmd.shift_byte && cmd.byte_sel == SEL_DATA) begin
        msg_bytes <= msg_bytes + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      for (int i = 0; i < NumWords; i++) begin
        dig[i] <= chain[i];
      end
    end else if (cmd.shift_out) begin
      for (int i = 0; i < NumWords - 1; i++) begin
        dig[i] <= dig[i+1];
      end
      dig[NumWords-1] <= '0;
    end
  end

  assign digest_word = dig[0];

endmodule

### sv/sha256_stream_hash_core.sv
// Bytes are taken while idle; a full 64-byte block then stalls input for its rounds and chain add,
// so sustained intake is set by the one-round-per-cycle round unit.
// End of message: padding, the eight length bytes, compression of one or two blocks (each its
// rounds plus chain add), the handover, then eight digest transfers from a drain buffer that
// overlaps the next message.
// Synchronous active-high reset: chain value to initial hash, counters cleared, output empty.
// Top level: SHA-256 stream hasher, controller plus datapath.
`timescale 1ns / 1ps

module sha256_stream_hash_core
  import sha256sh_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ByteW-1:0]    data_byte,
  input  logic                byte_valid,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [WordW-1:0]    digest_word,
  output logic [WordIdxW-1:0] word_index,
  output logic                last_word
);

  cmd_t cmd;

  sha256sh_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .byte_valid (byte_valid),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .last_word  (last_word),
    .cmd        (cmd)
  );

  sha256sh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (data_byte),
    .digest_word (digest_word)
  );

`ifndef NO_ASSERTIONS
  a_load_when_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !out_valid)
    else $error("digest handover while previous digest still draining");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=> !out_valid)
    else $error("output still valid after final digest word transfer");

  a_rounds_start: assert property (@(posedge clk) disable iff (rst)
    cmd.init_vars |=> cmd.round && cmd.round_idx == '0)
    else $error("compression did not start at round zero");

  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.round || cmd.add_chain |-> in_stall)
    else $error("input open during compression");
`endif

endmodule
